// File: src/tdmf_pkg.sv
package tdmf_pkg;

	// ring storage and pointer widths
	localparam int RING_DEPTH = 32;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int SIZE_W     = 6;

	// conditioner constants
	localparam logic [63:0] FNV_BASIS   = 64'hcbf2_9ce4_8422_2325;
	localparam int          PRIME_SHIFT = 40;
	localparam logic [8:0]  PRIME_LOW   = 9'h1b3;
	localparam int          WORD_BITS   = 64;
	localparam int          BATCH_MIXES = 8;
	localparam int          CNT_W       = $clog2(WORD_BITS);
	localparam int          ROUND_W     = $clog2(BATCH_MIXES);

	// input item kinds
	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_READ   = 2'd1,
		KIND_FLUSH  = 2'd2
	} kind_t;

	// field widths and stream widths
	localparam int IN_BITS   = 1 + 1 + 32 + 12;
	localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 32 + 1 + 1;
	localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

	// effective ring size: zero acts as one, clipped at the storage depth
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		r = s;
		if (s == '0) begin
			r = SIZE_W'(1);
		end else if (s > SIZE_W'(RING_DEPTH)) begin
			r = SIZE_W'(RING_DEPTH);
		end
		return r;
	endfunction

	// index advance with wrap at the effective size
	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
		input logic [SIZE_W-1:0] size);
		logic [SIZE_W:0] nx;
		nx = (SIZE_W + 1)'(idx) + (SIZE_W + 1)'(1);
		return (nx >= (SIZE_W + 1)'(size)) ? '0 : nx[IDX_W-1:0];
	endfunction

endpackage

// File: src/trng_debias_mix_fifo.sv
// channel   | signals                      | contents
// ----------+------------------------------+---------------------------------------
// in        | s_tvalid s_tready s_tdata    | tuser: kind; tdata: raw bits, time, adc
//           | s_tuser                      |
// out       | m_tvalid m_tready m_tdata    | tuser: read_valid; tdata: word, flags
//           | m_tuser                      |
// config    | cfg_we cfg_wdata             | ring_size, written any cycle it is high
//
// each item passes an input register, then one pass of debias, mix
// (xor, shift-and-add by the fnv prime) and ring update into the result register;
// a new item may enter the input register as the last one moves on, unless the result stalls
// arst_n clears pointers, flags and counters and loads the fnv basis into the accumulator;
// ring entries hold garbage until pushed
// a stalled result holds the input stage; the ring stays at 32 flop entries
module trng_debias_mix_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tdmf_pkg::SIZE_W-1:0]    cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// raw_bit_first, raw_bit_second, time_ms[31:0], adc_sample[11:0], zero pad
	input  logic [tdmf_pkg::IN_TDATA-1:0]  s_tdata,
	// kind[1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// read_data[31:0], fifo_empty, fifo_full, zero pad
	output logic [tdmf_pkg::OUT_TDATA-1:0] m_tdata,
	// read_valid
	output logic                           m_tuser
);

	localparam int IW = tdmf_pkg::IDX_W;
	localparam int SW = tdmf_pkg::SIZE_W;

	// configuration register
	logic [SW-1:0] ring_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= SW'(tdmf_pkg::RING_DEPTH);
		end else if (cfg_we) begin
			ring_size_q <= cfg_wdata;
		end
	end

	// input stage
	logic                     valid_s1;
	tdmf_pkg::kind_t          kind_s1;
	logic                     bit_a_s1;
	logic                     bit_b_s1;
	logic [31:0]              time_s1;
	logic [11:0]              adc_s1;
	logic                     advance;

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1  <= tdmf_pkg::kind_t'(s_tuser);
			bit_a_s1 <= s_tdata[0];
			bit_b_s1 <= s_tdata[1];
			time_s1  <= s_tdata[33:2];
			adc_s1   <= s_tdata[45:34];
		end
	end

	// conditioner and ring state
	logic [63:0]                    acc_q;
	logic [tdmf_pkg::ROUND_W-1:0]   round_q;
	logic [63:0]                    word_q;
	logic [tdmf_pkg::CNT_W-1:0]     count_q;
	logic [31:0]                    store_q [tdmf_pkg::RING_DEPTH];
	logic [IW-1:0]                  head_q;
	logic [IW-1:0]                  tail_q;
	logic                           full_q;
	logic                           empty_q;

	logic [SW-1:0]                  size_eff;
	logic [63:0]                    word_new;
	logic [63:0]                    mix_x;
	logic [63:0]                    mix_p;
	logic [IW-1:0]                  tail_1;
	logic [IW-1:0]                  tail_2;
	logic [IW-1:0]                  head_1;

	assign size_eff = tdmf_pkg::eff_size(ring_size_q);
	assign word_new = {word_q[62:0], bit_a_s1};
	assign tail_1   = tdmf_pkg::ring_next(tail_q, size_eff);
	assign tail_2   = tdmf_pkg::ring_next(tail_1, size_eff);
	assign head_1   = tdmf_pkg::ring_next(head_q, size_eff);

	// xor in the word, time and adc, then multiply by 2^40 + 0x1b3
	always_comb begin
		mix_x = ((round_q == '0) ? tdmf_pkg::FNV_BASIS : acc_q)
			^ word_new ^ 64'(time_s1) ^ 64'(adc_s1);
		mix_p = (mix_x << tdmf_pkg::PRIME_SHIFT) + (mix_x * 64'(tdmf_pkg::PRIME_LOW));
	end

	// next state and result for the item in the input stage
	logic                  take;
	logic                  word_done;
	logic                  batch_done;
	logic                  push_lo;
	logic                  push_hi;
	logic                  pop;
	logic                  flush;
	logic                  full_nx;
	logic                  empty_nx;
	logic [IW-1:0]         head_nx;
	logic [IW-1:0]         tail_nx;

	always_comb begin
		take       = 1'b0;
		pop        = 1'b0;
		flush      = 1'b0;
		case (kind_s1)
			tdmf_pkg::KIND_SAMPLE: take  = (bit_a_s1 != bit_b_s1);
			tdmf_pkg::KIND_READ:   pop   = !empty_q;
			tdmf_pkg::KIND_FLUSH:  flush = 1'b1;
			default: ;
		endcase
		word_done  = take && (count_q == '1);
		batch_done = word_done && (round_q == '1);
		push_lo    = batch_done && !full_q;
		push_hi    = push_lo && (tail_1 != head_q);

		head_nx  = head_q;
		tail_nx  = tail_q;
		full_nx  = full_q;
		empty_nx = empty_q;
		if (push_lo) begin
			empty_nx = 1'b0;
			if (push_hi) begin
				tail_nx = tail_2;
				full_nx = (tail_2 == head_q);
			end else begin
				tail_nx = tail_1;
				full_nx = 1'b1;
			end
		end
		if (pop) begin
			head_nx  = head_1;
			empty_nx = (head_1 == tail_q);
			full_nx  = 1'b0;
		end
		if (flush) begin
			head_nx  = tail_q;
			empty_nx = 1'b1;
			full_nx  = 1'b0;
		end
	end

	logic fire;

	assign fire = valid_s1 && advance;

	// control state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= tdmf_pkg::FNV_BASIS;
			round_q <= '0;
			word_q  <= '0;
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			full_q  <= 1'b0;
			empty_q <= 1'b1;
		end else if (fire) begin
			if (take) begin
				count_q <= count_q + 1'b1;
				word_q  <= word_done ? '0 : word_new;
			end
			if (word_done) begin
				acc_q   <= mix_p;
				round_q <= round_q + 1'b1;
			end
			head_q  <= head_nx;
			tail_q  <= tail_nx;
			full_q  <= full_nx;
			empty_q <= empty_nx;
		end
	end

	// ring entries
	always_ff @(posedge clk) begin
		if (fire && push_lo) begin
			store_q[tail_q] <= mix_p[31:0];
		end
		if (fire && push_hi) begin
			store_q[tail_1] <= mix_p[63:32];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tuser <= pop;
			m_tdata <= tdmf_pkg::OUT_TDATA'({full_nx, empty_nx,
				(pop ? store_q[head_q] : 32'd0)});
		end
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

	// fnv-64 prime and the code of the one kind the block does not know
	localparam logic [63:0] MIX_PRIME    = 64'h0000_0100_0000_01b3;
	localparam logic [1:0]  KIND_UNKNOWN = 2'd3;
	localparam int          STALL_LIMIT  = 2000;
	localparam int          N_PHASES     = 8;
	localparam int          PHASE_ITEMS  = 231;
	localparam int          N_DIRECTED   = 14;

	typedef struct packed {
		logic [1:0]  kind;
		logic        raw_first;
		logic        raw_second;
		logic [31:0] time_ms;
		logic [11:0] adc;
	} sample_item_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] data;
		logic        empty;
		logic        full;
	} ring_result_t;

	typedef struct packed {
		sample_item_t item;
		logic         typed;
		ring_result_t want;
	} directed_row_t;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [tdmf_pkg::SIZE_W-1:0]    cfg_wdata = '0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	// raw_bit_first, raw_bit_second, time_ms[31:0], adc_sample[11:0], zero pad
	logic [tdmf_pkg::IN_TDATA-1:0]  s_tdata   = '0;
	// kind[1:0]
	logic [1:0]                     s_tuser   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	// read_data[31:0], fifo_empty, fifo_full, zero pad
	logic [tdmf_pkg::OUT_TDATA-1:0] m_tdata;
	// read_valid
	logic                           m_tuser;

	// conditioner and ring state as the testbench tracks it
	logic [tdmf_pkg::SIZE_W-1:0] ring_cfg;
	logic [63:0]       mix_acc;
	int                mix_count;
	logic [63:0]       vn_word;
	int                vn_bits;
	logic [31:0]       ring_mem [tdmf_pkg::RING_DEPTH];
	bit                ring_written [tdmf_pkg::RING_DEPTH];
	int                rd_ptr;
	int                wr_ptr;
	bit                ring_full;
	bit                ring_empty;

	ring_result_t      expected_results [$];
	bit                no_idle     = 1'b0;
	int                errors      = 0;
	int                n_items     = 0;
	int                n_results   = 0;
	int                n_pushes    = 0;
	int                n_pops      = 0;
	int                n_drops     = 0;
	int                stall_left  = 0;
	int                quiet_count = 0;

	trng_debias_mix_fifo i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ring size in effect: zero acts as one, clipped at the storage depth
	function automatic int ring_limit();
		int s;
		s = int'(ring_cfg);
		if (s < 1) s = 1;
		if (s > tdmf_pkg::RING_DEPTH) s = tdmf_pkg::RING_DEPTH;
		return s;
	endfunction

	function automatic int ring_step(input int idx);
		return (idx + 1 >= ring_limit()) ? 0 : idx + 1;
	endfunction

	function automatic void push_word(input logic [31:0] w);
		ring_mem[wr_ptr] = w;
		ring_written[wr_ptr] = 1'b1;
		wr_ptr = ring_step(wr_ptr);
		if (wr_ptr == rd_ptr) ring_full = 1'b1;
		ring_empty = 1'b0;
		n_pushes++;
	endfunction

	function automatic void clear_state();
		ring_cfg = tdmf_pkg::SIZE_W'(tdmf_pkg::RING_DEPTH);
		mix_acc = tdmf_pkg::FNV_BASIS;
		mix_count = 0;
		vn_word = '0;
		vn_bits = 0;
		rd_ptr = 0;
		wr_ptr = 0;
		ring_full = 1'b0;
		ring_empty = 1'b1;
		for (int i = 0; i < tdmf_pkg::RING_DEPTH; i++) ring_written[i] = 1'b0;
	endfunction

	// debias, mix, ring update for one accepted item; returns the expected result
	function automatic ring_result_t condition_item(input sample_item_t it);
		ring_result_t r;
		r = '0;
		if (it.kind == tdmf_pkg::KIND_SAMPLE) begin
			if (it.raw_first != it.raw_second) begin
				vn_word = {vn_word[62:0], it.raw_first};
				vn_bits++;
				if (vn_bits == tdmf_pkg::WORD_BITS) begin
					vn_bits = 0;
					if (mix_count == 0) mix_acc = tdmf_pkg::FNV_BASIS;
					mix_acc = (mix_acc ^ vn_word ^ {32'd0, it.time_ms} ^ {52'd0, it.adc})
						* MIX_PRIME;
					vn_word = '0;
					mix_count++;
					if (mix_count == tdmf_pkg::BATCH_MIXES) begin
						mix_count = 0;
						// a full ring drops both words; a fill by the low word drops the high one
						if (ring_full) begin
							n_drops += 2;
						end else begin
							push_word(mix_acc[31:0]);
							if (ring_full) n_drops++;
							else push_word(mix_acc[63:32]);
						end
					end
				end
			end
		end else if (it.kind == tdmf_pkg::KIND_READ) begin
			if (!ring_empty) begin
				r.valid = 1'b1;
				r.data = ring_mem[rd_ptr];
				rd_ptr = ring_step(rd_ptr);
				if (rd_ptr == wr_ptr) ring_empty = 1'b1;
				ring_full = 1'b0;
				n_pops++;
			end
		end else if (it.kind == tdmf_pkg::KIND_FLUSH) begin
			rd_ptr = wr_ptr;
			ring_empty = 1'b1;
			ring_full = 1'b0;
		end
		r.empty = ring_empty;
		r.full = ring_full;
		return r;
	endfunction

	function automatic sample_item_t make_item(input logic [1:0] kind, input logic first,
		input logic second, input logic [31:0] t, input logic [11:0] adc);
		sample_item_t it;
		it.kind = kind;
		it.raw_first = first;
		it.raw_second = second;
		it.time_ms = t;
		it.adc = adc;
		return it;
	endfunction

	// one input transfer, then an optional idle burst
	task automatic send_item(input sample_item_t it, input logic typed, input ring_result_t want);
		ring_result_t r;
		s_tuser <= it.kind;
		s_tdata <= tdmf_pkg::IN_TDATA'({it.adc, it.time_ms, it.raw_second, it.raw_first});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		r = condition_item(it);
		if (typed) r = want;
		expected_results.push_back(r);
		n_items++;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// stop sending and wait until the block has answered every item
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ring_size(input logic [tdmf_pkg::SIZE_W-1:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		ring_cfg = v;
		cfg_we <= 1'b0;
	endtask

	// mostly sample pairs with unequal bits, some reads, rare flushes and unknown kinds
	task automatic run_random(input int count);
		sample_item_t it;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			it.time_ms = $urandom;
			it.adc = 12'($urandom);
			it.raw_first = 1'($urandom);
			it.raw_second = 1'($urandom);
			if (r < 84) begin
				it.kind = tdmf_pkg::KIND_SAMPLE;
				if ($urandom_range(0, 9) != 0) it.raw_second = ~it.raw_first;
			end else if (r < 96) begin
				it.kind = tdmf_pkg::KIND_READ;
			end else if (r < 98) begin
				it.kind = tdmf_pkg::KIND_FLUSH;
			end else begin
				it.kind = KIND_UNKNOWN;
			end
			// an entry left unwritten after a size change must never be popped
			if (it.kind == tdmf_pkg::KIND_READ && !ring_empty && !ring_written[rd_ptr])
				it.kind = tdmf_pkg::KIND_FLUSH;
			send_item(it, 1'b0, '0);
		end
	endtask

	task automatic report_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
	endtask

	// result side: random stall bursts until the last phase
	always @(posedge clk) begin
		if (no_idle) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		ring_result_t got;
		ring_result_t want;
		if (m_tvalid && m_tready) begin
			got.valid = m_tuser;
			got.data = m_tdata[31:0];
			got.empty = m_tdata[32];
			got.full = m_tdata[33];
			n_results++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual %0h", $time, got);
			end else begin
				want = expected_results.pop_front();
				if (got.valid !== want.valid) report_field("read_valid", want.valid, got.valid);
				if (got.data !== want.data) report_field("read_data", want.data, got.data);
				if (got.empty !== want.empty) report_field("fifo_empty", want.empty, got.empty);
				if (got.full !== want.full) report_field("fifo_full", want.full, got.full);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_count = 0;
		else quiet_count++;
		if (quiet_count >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		directed_row_t dir_tab [N_DIRECTED];
		ring_result_t  idle_empty;
		logic [tdmf_pkg::SIZE_W-1:0] sizes [N_PHASES];

		idle_empty = '{valid: 1'b0, data: 32'd0, empty: 1'b1, full: 1'b0};
		sizes = '{6'd1, 6'd2, 6'd0, 6'd63, 6'd3, 6'd33, 6'd4, 6'd32};

		// directed items: reset state, field extremes, every kind
		dir_tab[0]  = '{make_item(tdmf_pkg::KIND_READ, 0, 0, 32'd0, 12'd0), 1'b1, idle_empty};
		dir_tab[1]  = '{make_item(tdmf_pkg::KIND_FLUSH, 0, 0, 32'd0, 12'd0), 1'b1, idle_empty};
		dir_tab[2]  = '{make_item(KIND_UNKNOWN, 1, 1, 32'hffff_ffff, 12'hfff), 1'b1,
			idle_empty};
		dir_tab[3]  = '{make_item(tdmf_pkg::KIND_SAMPLE, 0, 0, 32'd0, 12'd0), 1'b1, idle_empty};
		dir_tab[4]  = '{make_item(tdmf_pkg::KIND_SAMPLE, 1, 1, 32'hffff_ffff, 12'hfff), 1'b1,
			idle_empty};
		dir_tab[5]  = '{make_item(tdmf_pkg::KIND_SAMPLE, 1, 0, 32'hffff_ffff, 12'hfff), 1'b1,
			idle_empty};
		dir_tab[6]  = '{make_item(tdmf_pkg::KIND_SAMPLE, 0, 1, 32'd0, 12'd0), 1'b1, idle_empty};
		dir_tab[7]  = '{make_item(tdmf_pkg::KIND_READ, 1, 1, 32'hffff_ffff, 12'hfff), 1'b1,
			idle_empty};
		dir_tab[8]  = '{make_item(tdmf_pkg::KIND_SAMPLE, 1, 0, 32'h8000_0000, 12'h800), 1'b0,
			'0};
		dir_tab[9]  = '{make_item(tdmf_pkg::KIND_SAMPLE, 0, 1, 32'd1, 12'd1), 1'b0, '0};
		dir_tab[10] = '{make_item(tdmf_pkg::KIND_FLUSH, 1, 0, 32'h1234_5678, 12'habc), 1'b0,
			'0};
		dir_tab[11] = '{make_item(KIND_UNKNOWN, 0, 0, 32'd0, 12'd0), 1'b0, '0};
		dir_tab[12] = '{make_item(tdmf_pkg::KIND_SAMPLE, 0, 1, 32'haaaa_5555, 12'h5a5), 1'b0,
			'0};
		dir_tab[13] = '{make_item(tdmf_pkg::KIND_READ, 0, 1, 32'h5555_aaaa, 12'ha5a), 1'b0,
			'0};

		clear_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
		drain_block();

		// random phases, one ring size each, the last one without idling
		for (int p = 0; p < N_PHASES; p++) begin
			write_ring_size(sizes[p]);
			if (p == N_PHASES - 1) no_idle = 1'b1;
			run_random(PHASE_ITEMS);
			drain_block();
		end
		repeat (8) @(posedge clk);

		$display("ran %0d items with %0d results: %0d words pushed, %0d popped, %0d dropped",
			n_items, n_results, n_pushes, n_pops, n_drops);
		$display("ring sizes 32 1 2 0 63 3 33 4 32 with reads, flushes and unknown kinds mixed in");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
